// File: src/lerc_pkg.sv
`timescale 1ns / 1ps

package lerc_pkg;

	localparam int DEPTH = 1024;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;
	localparam int IDX_W = 48;
	localparam int TERM_W = 32;
	localparam int ID_W = 32;
	localparam int KIND_W = 8;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 64;

	localparam logic [2:0] MODE_APPEND    = 3'd0;
	localparam logic [2:0] MODE_DROP_TAIL = 3'd1;
	localparam logic [2:0] MODE_DROP_HEAD = 3'd2;
	localparam logic [2:0] MODE_READ      = 3'd3;
	localparam logic [2:0] MODE_MARK      = 3'd4;

	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_FULL     = 3'd1;
	localparam logic [2:0] STS_EMPTY    = 3'd2;
	localparam logic [2:0] STS_NOT_HELD = 3'd3;
	localparam logic [2:0] STS_BAD_MARK = 3'd4;

	localparam logic [ADDR_W-4:0] REG_START_INDEX = '0;

	typedef struct packed {
		logic [2:0]        mode;
		logic [IDX_W-1:0]  log_index;
		logic [TERM_W-1:0] entry_term;
		logic [ID_W-1:0]   entry_id;
		logic [KIND_W-1:0] entry_kind;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [TERM_W-1:0] read_term;
		logic [ID_W-1:0]   read_id;
		logic [KIND_W-1:0] read_kind;
		logic [CNT_W-1:0]  entry_count;
		logic [IDX_W-1:0]  first_index;
		logic [IDX_W-1:0]  last_index;
		logic [IDX_W-1:0]  mark_index;
	} rsp_t;

	typedef struct packed {
		logic [TERM_W-1:0] term;
		logic [ID_W-1:0]   id;
		logic [KIND_W-1:0] kind;
	} entry_t;

	typedef struct packed {
		logic take;
		logic check;
		logic apply;
		logic load;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
	} ctl_stat_t;

endpackage

// File: src/log_entry_ring_cache.sv
`timescale 1ns / 1ps

// Ring store of up to 1024 log entries addressed by 1-based log index, with
// append, drop at either end, read by index and mark advance; every item gives
// one result with status, the entry read, the count, first and last held index
// and the mark. An item passes through the steps accept, range and mark checks,
// state update with the memory access and result load, and a new item is taken
// only after the last one's result is loaded, set by the controller sequence
// around the single-port registered entry memory; a stalled result holds the
// fourth step of the next item, and the next item is taken the cycle after a
// result is loaded, even while it waits. There is no clearing pass after reset.
// start_index sits at byte address 0 (64-bit data, low 48 bits used); the user
// must write it only while the block is idle, which the block does not enforce.
module log_entry_ring_cache (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  lerc_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output lerc_pkg::rsp_t                rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lerc_pkg::ADDR_W-1:0]   paddr,
	input  logic [lerc_pkg::DATA_W-1:0]   pwdata,
	output logic [lerc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	lerc_pkg::ctl_cmd_t             cmd;
	lerc_pkg::ctl_stat_t            stat;
	logic                           cfg_we;
	logic                           reg_hit;
	logic [lerc_pkg::IDX_W-1:0]     start_index;

	assign reg_hit = (paddr[lerc_pkg::ADDR_W-1:3] == lerc_pkg::REG_START_INDEX);
	assign cfg_we  = psel && penable && pwrite && reg_hit;
	assign pready  = 1'b1;
	assign prdata  = reg_hit
		? {{(lerc_pkg::DATA_W-lerc_pkg::IDX_W){1'b0}}, start_index} : '0;

	lerc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lerc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req         (req),
		.cfg_we      (cfg_we),
		.cfg_wdata   (pwdata[lerc_pkg::IDX_W-1:0]),
		.start_index (start_index),
		.rsp         (rsp),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready)
	);

endmodule

// File: src/lerc_ctrl.sv
`timescale 1ns / 1ps

module lerc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  lerc_pkg::ctl_stat_t stat,
	output lerc_pkg::ctl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		IDLE,
		CHECK,
		APPLY,
		WB
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE: begin
					if (req_valid) begin
						state_q <= CHECK;
					end
				end
				CHECK: state_q <= APPLY;
				APPLY: state_q <= WB;
				WB: begin
					if (stat.out_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == IDLE);

	always_comb begin
		cmd.take  = (state_q == IDLE) && req_valid;
		cmd.check = (state_q == CHECK);
		cmd.apply = (state_q == APPLY);
		cmd.load  = (state_q == WB) && stat.out_free;
	end

endmodule

// File: src/lerc_dp.sv
`timescale 1ns / 1ps

module lerc_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lerc_pkg::ctl_cmd_t             cmd,
	output lerc_pkg::ctl_stat_t            stat,
	input  lerc_pkg::req_t                 req,
	input  logic                           cfg_we,
	input  logic [lerc_pkg::IDX_W-1:0]     cfg_wdata,
	output logic [lerc_pkg::IDX_W-1:0]     start_index,
	output lerc_pkg::rsp_t                 rsp,
	output logic                           rsp_valid,
	input  logic                           rsp_ready
);

	localparam int PTR_W = lerc_pkg::PTR_W;
	localparam int CNT_W = lerc_pkg::CNT_W;
	localparam int IDX_W = lerc_pkg::IDX_W;

	lerc_pkg::entry_t mem_q [lerc_pkg::DEPTH];
	lerc_pkg::entry_t rdata_q;

	lerc_pkg::req_t   item_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] first_q;
	logic [IDX_W-1:0] last_q;
	logic [IDX_W-1:0] mark_q;
	logic [IDX_W-1:0] start_q;

	logic [PTR_W-1:0] off_s1;
	logic             hit_s1;
	logic             mark_ok_s1;
	logic             full_s1;
	logic             empty_s1;

	logic [2:0]       status_s2;
	logic             hit_s2;

	lerc_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	logic [IDX_W-1:0] off;
	logic [IDX_W-1:0] count_ext;
	logic [IDX_W-1:0] mark_nxt;
	logic             mem_we;
	logic             mem_re;
	logic [PTR_W-1:0] rd_addr;
	logic [2:0]       status_nxt;

	assign count_ext = {{(IDX_W-CNT_W){1'b0}}, count_q};
	assign off       = item_q.log_index - first_q;
	assign mark_nxt  = mark_q + IDX_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= req;
		end
	end

	// checks that need a wide add or compare, registered ahead of the update
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			off_s1     <= off[PTR_W-1:0];
			hit_s1     <= (item_q.log_index != '0) && (off[IDX_W-1:CNT_W] == '0)
				&& (off[CNT_W-1:0] < count_q);
			mark_ok_s1 <= (item_q.log_index == mark_nxt) && (item_q.log_index > last_q);
			full_s1    <= (count_q == CNT_W'(lerc_pkg::DEPTH));
			empty_s1   <= (count_q == '0);
		end
	end

	always_comb begin
		status_nxt = lerc_pkg::STS_OK;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		case (item_q.mode)
			lerc_pkg::MODE_APPEND: begin
				if (full_s1) begin
					status_nxt = lerc_pkg::STS_FULL;
				end else begin
					mem_we = cmd.apply;
				end
			end
			lerc_pkg::MODE_DROP_TAIL, lerc_pkg::MODE_DROP_HEAD: begin
				if (empty_s1) begin
					status_nxt = lerc_pkg::STS_EMPTY;
				end
			end
			lerc_pkg::MODE_READ: begin
				if (!hit_s1) begin
					status_nxt = lerc_pkg::STS_NOT_HELD;
				end else begin
					mem_re = cmd.apply;
				end
			end
			lerc_pkg::MODE_MARK: begin
				if (!mark_ok_s1) begin
					status_nxt = lerc_pkg::STS_BAD_MARK;
				end
			end
			default: status_nxt = lerc_pkg::STS_OK;
		endcase
	end

	assign rd_addr = head_q + off_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[tail_q] <= '{term: item_q.entry_term, id: item_q.entry_id,
				kind: item_q.entry_kind};
		end
		if (mem_re) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			status_s2 <= status_nxt;
			hit_s2    <= (item_q.mode == lerc_pkg::MODE_READ) && hit_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			first_q <= IDX_W'(1);
			last_q  <= '0;
			mark_q  <= '0;
			start_q <= IDX_W'(1);
		end else if (cfg_we) begin
			start_q <= cfg_wdata;
			first_q <= cfg_wdata;
			last_q  <= cfg_wdata + count_ext - IDX_W'(1);
		end else if (cmd.apply && (status_nxt == lerc_pkg::STS_OK)) begin
			case (item_q.mode)
				lerc_pkg::MODE_APPEND: begin
					tail_q  <= tail_q + PTR_W'(1);
					count_q <= count_q + CNT_W'(1);
					last_q  <= last_q + IDX_W'(1);
				end
				lerc_pkg::MODE_DROP_TAIL: begin
					tail_q  <= tail_q - PTR_W'(1);
					count_q <= count_q - CNT_W'(1);
					last_q  <= last_q - IDX_W'(1);
				end
				lerc_pkg::MODE_DROP_HEAD: begin
					// last stays: base moves up as count moves down
					head_q  <= head_q + PTR_W'(1);
					count_q <= count_q - CNT_W'(1);
					first_q <= first_q + IDX_W'(1);
				end
				lerc_pkg::MODE_MARK: mark_q <= item_q.log_index;
				default: mark_q <= mark_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q.status      <= status_s2;
			rsp_q.read_term   <= hit_s2 ? rdata_q.term : '0;
			rsp_q.read_id     <= hit_s2 ? rdata_q.id : '0;
			rsp_q.read_kind   <= hit_s2 ? rdata_q.kind : '0;
			rsp_q.entry_count <= count_q;
			rsp_q.first_index <= first_q;
			rsp_q.last_index  <= last_q;
			rsp_q.mark_index  <= mark_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign stat.out_free = !rsp_valid_q || rsp_ready;
	assign rsp           = rsp_q;
	assign rsp_valid     = rsp_valid_q;
	assign start_index   = start_q;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import lerc_pkg::*;

	localparam int REG_STRIDE = 8;
	localparam int REG_SPARE = 1;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_CAP = 100;
	localparam logic [ADDR_W-1:0] START_ADDR = ADDR_W'(int'(REG_START_INDEX) * REG_STRIDE);
	localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(REG_SPARE * REG_STRIDE);
	localparam logic [IDX_W-1:0] IDX_MAX = '1;
	localparam logic [2:0] MODE_SPARE_FIRST = MODE_MARK + 3'd1;
	localparam logic [2:0] MODE_SPARE_LAST = '1;

	typedef struct {
		int append;
		int drop_tail;
		int drop_head;
		int read_at;
		int mark_step;
		int spare;
	} mode_mix_t;

	typedef struct {
		req_t item;
		bit   known;
		rsp_t known_rsp;
	} step_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_t              req_item = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	rsp_t              rsp_item;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// predicted ring contents and registers
	entry_t           ring_mem [DEPTH];
	logic [PTR_W-1:0] ring_head = '0;
	logic [PTR_W-1:0] ring_tail = '0;
	logic [CNT_W-1:0] ring_count = '0;
	logic [IDX_W-1:0] ring_base = '0;
	logic [IDX_W-1:0] ring_mark = '0;

	rsp_t      ring_results_due [$];
	step_row_t dir_rows [$];
	int        mismatch_count = 0;
	int        idle_cycles = 0;
	int        stall_left = 0;
	int        calm_left = 0;

	log_entry_ring_cache i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatch_count < REPORT_CAP)
			$display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// applies one item to the predicted ring and returns the result it gives
	function automatic rsp_t compute_ring_result(input req_t it);
		rsp_t             res;
		logic [IDX_W-1:0] last_idx;
		logic [IDX_W-1:0] off;
		logic [PTR_W-1:0] slot;
		res = '0;
		res.status = STS_OK;
		last_idx = ring_base + IDX_W'(ring_count);
		case (it.mode)
			MODE_APPEND: begin
				if (ring_count >= DEPTH) begin
					res.status = STS_FULL;
				end else begin
					ring_mem[ring_tail] = {it.entry_term, it.entry_id, it.entry_kind};
					ring_tail = ring_tail + 1'b1;
					ring_count = ring_count + 1'b1;
				end
			end
			MODE_DROP_TAIL: begin
				if (ring_count == '0) begin
					res.status = STS_EMPTY;
				end else begin
					ring_tail = ring_tail - 1'b1;
					ring_count = ring_count - 1'b1;
				end
			end
			MODE_DROP_HEAD: begin
				if (ring_count == '0) begin
					res.status = STS_EMPTY;
				end else begin
					ring_head = ring_head + 1'b1;
					ring_count = ring_count - 1'b1;
					ring_base = ring_base + 1'b1;
				end
			end
			MODE_READ: begin
				off = it.log_index - 48'd1 - ring_base;
				if (it.log_index == '0 || off >= IDX_W'(ring_count)) begin
					res.status = STS_NOT_HELD;
				end else begin
					// power-of-two depth, so the slot wraps by truncation
					slot = ring_head + off[PTR_W-1:0];
					res.read_term = ring_mem[slot].term;
					res.read_id = ring_mem[slot].id;
					res.read_kind = ring_mem[slot].kind;
				end
			end
			MODE_MARK: begin
				if (it.log_index != ring_mark + 48'd1 || it.log_index <= last_idx)
					res.status = STS_BAD_MARK;
				else
					ring_mark = it.log_index;
			end
			default: begin
			end
		endcase
		res.entry_count = ring_count;
		res.first_index = ring_base + 48'd1;
		res.last_index = ring_base + IDX_W'(ring_count);
		res.mark_index = ring_mark;
		return res;
	endfunction

	// mostly well-formed indexes around the held range and the mark, some noise
	function automatic req_t random_item(input mode_mix_t m);
		req_t it;
		int   total;
		int   pick;
		int   roll;
		total = m.append + m.drop_tail + m.drop_head + m.read_at + m.mark_step + m.spare;
		pick = $urandom_range(1, total);
		roll = $urandom_range(0, 9);
		it.log_index = {16'($urandom), $urandom};
		it.entry_term = $urandom;
		it.entry_id = $urandom;
		it.entry_kind = 8'($urandom);
		if (pick <= m.append) begin
			it.mode = MODE_APPEND;
		end else if (pick <= m.append + m.drop_tail) begin
			it.mode = MODE_DROP_TAIL;
		end else if (pick <= m.append + m.drop_tail + m.drop_head) begin
			it.mode = MODE_DROP_HEAD;
		end else if (pick <= m.append + m.drop_tail + m.drop_head + m.read_at) begin
			it.mode = MODE_READ;
			if (roll < 7)
				it.log_index = ring_base + IDX_W'($urandom_range(0, int'(ring_count) + 3))
					- 48'd1;
			else if (roll == 7)
				it.log_index = '0;
		end else if (pick <= total - m.spare) begin
			it.mode = MODE_MARK;
			if (roll < 7)
				it.log_index = ring_mark + 48'd1;
			else if (roll < 9)
				it.log_index = ring_mark + IDX_W'($urandom_range(0, 3));
		end else begin
			it.mode = 3'($urandom_range(int'(MODE_SPARE_FIRST), int'(MODE_SPARE_LAST)));
		end
		return it;
	endfunction

	task automatic add_row(input logic [2:0] mode, input logic [IDX_W-1:0] idx,
			input logic [TERM_W-1:0] term, input logic [ID_W-1:0] id,
			input logic [KIND_W-1:0] kind);
		step_row_t r;
		r.item = {mode, idx, term, id, kind};
		r.known = 1'b0;
		r.known_rsp = '0;
		dir_rows.push_back(r);
	endtask

	task automatic add_known(input logic [2:0] mode, input logic [IDX_W-1:0] idx,
			input logic [2:0] status, input logic [CNT_W-1:0] cnt,
			input logic [IDX_W-1:0] first_idx, input logic [IDX_W-1:0] last_idx,
			input logic [IDX_W-1:0] mark_idx);
		step_row_t r;
		r.item = '0;
		r.item.mode = mode;
		r.item.log_index = idx;
		r.known = 1'b1;
		r.known_rsp = '0;
		r.known_rsp.status = status;
		r.known_rsp.entry_count = cnt;
		r.known_rsp.first_index = first_idx;
		r.known_rsp.last_index = last_idx;
		r.known_rsp.mark_index = mark_idx;
		dir_rows.push_back(r);
	endtask

	task automatic send_item(input req_t it, input bit known, input rsp_t known_rsp);
		int   gap;
		rsp_t want;
		gap = (calm_left != 0) ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item <= it;
		do @(posedge clk); while (!req_ready);
		want = compute_ring_result(it);
		ring_results_due.push_back(known ? known_rsp : want);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (ring_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// only start_index exists; it moves the base and nothing else
		if (addr == START_ADDR)
			ring_base = data[IDX_W-1:0] - 48'd1;
	endtask

	task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(input logic [IDX_W-1:0] start_value, input mode_mix_t m,
			input int n);
		logic [DATA_W-1:0] got;
		wait_idle();
		apb_write(START_ADDR, DATA_W'(start_value));
		apb_read(START_ADDR, got);
		check_field("start_index readback", 64'(got[IDX_W-1:0]), 64'(start_value));
		repeat (n) send_item(random_item(m), 1'b0, '0);
	endtask

	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (ring_results_due.size() == 0) begin
				report_mismatch("result with none expected", 64'(rsp_item.status), '0);
			end else begin
				want = ring_results_due.pop_front();
				check_field("status", 64'(rsp_item.status), 64'(want.status));
				check_field("read_term", 64'(rsp_item.read_term), 64'(want.read_term));
				check_field("read_id", 64'(rsp_item.read_id), 64'(want.read_id));
				check_field("read_kind", 64'(rsp_item.read_kind), 64'(want.read_kind));
				check_field("entry_count", 64'(rsp_item.entry_count),
					64'(want.entry_count));
				check_field("first_index", 64'(rsp_item.first_index),
					64'(want.first_index));
				check_field("last_index", 64'(rsp_item.last_index), 64'(want.last_index));
				check_field("mark_index", 64'(rsp_item.mark_index), 64'(want.mark_index));
			end
		end
	end

	// result-side stalls, with calm stretches where neither side idles
	always @(posedge clk) begin
		if (calm_left != 0)
			calm_left <= calm_left - 1;
		else if ($urandom_range(0, 399) == 0)
			calm_left <= $urandom_range(100, 300);
		if (stall_left != 0) begin
			rsp_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rsp_ready <= 1'b1;
			if (calm_left == 0)
				stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [DATA_W-1:0] got;

		// empty store, reset base and mark
		add_known(MODE_DROP_TAIL, '0, STS_EMPTY, '0, 48'd1, '0, '0);
		add_known(MODE_DROP_HEAD, IDX_MAX, STS_EMPTY, '0, 48'd1, '0, '0);
		add_known(MODE_READ, '0, STS_NOT_HELD, '0, 48'd1, '0, '0);
		add_known(MODE_MARK, 48'd1, STS_OK, '0, 48'd1, '0, 48'd1);
		add_known(MODE_MARK, 48'd3, STS_BAD_MARK, '0, 48'd1, '0, 48'd1);
		add_row(MODE_APPEND, '0, '1, '0, '1);
		add_row(MODE_MARK, 48'd2, '0, '0, '0);
		add_row(MODE_APPEND, IDX_MAX, '0, '1, '0);
		add_row(MODE_MARK, 48'd3, '1, '1, '1);
		add_row(MODE_READ, 48'd1, '0, '0, '0);
		add_row(MODE_READ, 48'd2, '0, '0, '0);
		add_row(MODE_READ, 48'd3, '0, '0, '0);
		add_row(MODE_READ, IDX_MAX, '0, '0, '0);
		add_row(MODE_APPEND, '0, 32'h1234_5678, 32'h9abc_def0, 8'h5a);
		add_row(MODE_APPEND, '0, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 8'ha5);
		// next mark step but not past the newest index
		add_row(MODE_MARK, 48'd4, '0, '0, '0);
		add_row(MODE_DROP_HEAD, '0, '0, '0, '0);
		add_row(MODE_READ, 48'd1, '0, '0, '0);
		add_row(MODE_READ, 48'd2, '0, '0, '0);
		add_row(MODE_DROP_TAIL, '0, '0, '0, '0);
		add_row(MODE_SPARE_LAST, IDX_MAX, '1, '1, '1);
		add_row(MODE_SPARE_FIRST, 48'd2, 32'hdead_beef, 32'h0bad_f00d, 8'h3c);
		add_row(MODE_MARK, IDX_MAX, '0, '0, '0);
		add_row(MODE_READ, 48'd3, '0, '0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_read(START_ADDR, got);
		check_field("start_index after reset", 64'(got[IDX_W-1:0]), 64'd1);

		foreach (dir_rows[i])
			send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].known_rsp);

		// a write to an unmapped register must leave everything alone
		wait_idle();
		apb_write(SPARE_ADDR, {$urandom, $urandom});

		// near-empty churn with the base at the top, so indexes wrap
		run_phase(IDX_MAX, '{35, 10, 25, 18, 10, 2}, 300);
		// fill up and keep pushing against full
		run_phase({16'($urandom_range(1, 65534)), $urandom}, '{94, 0, 1, 3, 1, 1}, 1150);
		// drain from both ends
		run_phase(48'd1, '{10, 30, 45, 10, 4, 1}, 400);

		wait_idle();
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
src/lerc_pkg.sv
src/lerc_ctrl.sv
src/lerc_dp.sv
src/log_entry_ring_cache.sv
verif/testbench.sv
